>>> sv/cpct_pkg.sv
package cpct_pkg;

  localparam int NUM_PLATES = 3;
  localparam int COUNT_W    = 24;
  localparam int PLATE_W    = 2;
  localparam int SENSE_W    = 3;
  localparam int READING_W  = 40;
  localparam int SHIFT_W    = 5;
  localparam int WINDOW_W   = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_CNT_W  = $clog2(READING_W + 1);

  localparam logic [SHIFT_W-1:0]  MAX_SHIFT    = SHIFT_W'(16);
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(640000);
  localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = SHIFT_W'(10);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT  = CFG_IDX_W'(1);

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } state_t;

  typedef enum logic {
    PH_DISCHARGE,
    PH_CHARGE
  } phase_t;

endpackage

>>> sv/cpct_sense_if.sv
interface cpct_sense_if;
  logic                          valid;
  logic                          ready;
  logic [cpct_pkg::SENSE_W-1:0]  sense_levels;

  modport source (output valid, output sense_levels, input ready);
  modport sink   (input valid, input sense_levels, output ready);
endinterface

>>> sv/cpct_result_if.sv
interface cpct_result_if;
  logic                            valid;
  logic                            ready;
  logic [cpct_pkg::SENSE_W-1:0]    discharge_drive;
  logic                            reading_valid;
  logic [cpct_pkg::PLATE_W-1:0]    plate_index;
  logic [cpct_pkg::READING_W-1:0]  reading;

  modport source (output valid, output discharge_drive, output reading_valid,
                  output plate_index, output reading, input ready);
  modport sink   (input valid, input discharge_drive, input reading_valid,
                  input plate_index, input reading, output ready);
endinterface

>>> sv/cpct_cfg_if.sv
interface cpct_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cpct_pkg::CFG_IDX_W-1:0]   index;
  logic [cpct_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/capacitive_plate_charge_timer.sv
// Capacitive plate charge timer.
// Channels: sense (one transaction per clock tick of the sensed plates, carrying
// sense_levels), result (one transaction per sense transaction: discharge_drive,
// reading_valid, plate_index, reading) and cfg (register writes: index 0 is
// window_ticks, index 1 is scale_shift; always ready).
// Plates are measured in turn X, Y, Z. Each window discharges the plate, counts
// low ticks until the sense line rises, and repeats until the window expires.
// An ordinary tick's result sits in the output register in the cycle after its
// transaction. A window-end tick loads a bit-serial restoring divider that
// retires one quotient bit per cycle; its result enters the output register once
// every quotient bit is done, and sense is not ready meanwhile.
// Throughput: one tick per cycle while results are taken, except a window end,
// which holds the block until its divided result is registered.
// Reset (synchronous, active high) returns to discharge phase on plate X with
// all counters cleared and registers at window_ticks 640000, scale_shift 10.
// If the receiver stalls, the result stays in the output register and sense
// ready drops until it is taken; no transaction is lost.
module capacitive_plate_charge_timer (
  input  logic                 clk,
  input  logic                 rst,
  cpct_sense_if.sink           sense,
  cpct_result_if.source        result,
  cpct_cfg_if.sink             cfg
);

  cpct_pkg::state_t state, state_next;
  cpct_pkg::phase_t phase;

  logic [cpct_pkg::WINDOW_W-1:0]  window_ticks;
  logic [cpct_pkg::SHIFT_W-1:0]   scale_shift;
  logic [cpct_pkg::PLATE_W-1:0]   plate;
  logic [cpct_pkg::COUNT_W-1:0]   charge_ticks;
  logic [cpct_pkg::COUNT_W-1:0]   cycle_count;
  logic [cpct_pkg::COUNT_W-1:0]   elapsed_ticks;

  // divider
  logic [cpct_pkg::COUNT_W-1:0]   divisor;
  logic [cpct_pkg::COUNT_W-1:0]   rem;
  logic [cpct_pkg::READING_W-1:0] quo;
  logic [cpct_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                           div_zero;
  logic [cpct_pkg::PLATE_W-1:0]   div_plate;

  // output register
  logic                           out_valid;
  logic [cpct_pkg::SENSE_W-1:0]   out_drive;
  logic                           out_rd_valid;
  logic [cpct_pkg::PLATE_W-1:0]   out_plate;
  logic [cpct_pkg::READING_W-1:0] out_reading;

  logic                           out_free;
  logic                           accept;
  logic                           level;
  logic                           window_end;
  logic                           div_done;
  logic [cpct_pkg::PLATE_W-1:0]   plate_inc;
  logic [cpct_pkg::SENSE_W-1:0]   drive;
  logic [cpct_pkg::SHIFT_W-1:0]   sh;
  logic [cpct_pkg::READING_W-1:0] dividend;
  logic [cpct_pkg::COUNT_W:0]     rem_sh;
  logic [cpct_pkg::COUNT_W+1:0]   diff;
  logic                           ge;

  assign out_free   = !out_valid || result.ready;
  assign accept     = sense.valid && sense.ready;
  assign level      = sense.sense_levels[plate];
  assign window_end = (phase == cpct_pkg::PH_DISCHARGE) && (elapsed_ticks >= window_ticks);
  assign plate_inc  = (plate == cpct_pkg::PLATE_W'(cpct_pkg::NUM_PLATES - 1)) ?
                      '0 : plate + cpct_pkg::PLATE_W'(1);
  assign drive      = cpct_pkg::SENSE_W'(1) << plate;
  assign sh         = (scale_shift > cpct_pkg::MAX_SHIFT) ? cpct_pkg::MAX_SHIFT : scale_shift;
  assign dividend   = cpct_pkg::READING_W'(charge_ticks) << sh;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign rem_sh = {rem, quo[cpct_pkg::READING_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, divisor};
  assign ge     = !diff[cpct_pkg::COUNT_W+1];

  assign cfg.ready = 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      cpct_pkg::ST_RUN: begin
        if (accept && window_end) state_next = cpct_pkg::ST_DIV;
      end
      cpct_pkg::ST_DIV: begin
        if (div_cnt == '0 && out_free) state_next = cpct_pkg::ST_RUN;
      end
      default: state_next = cpct_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    sense.ready = 1'b0;
    div_done    = 1'b0;
    unique case (state)
      cpct_pkg::ST_RUN: sense.ready = out_free;
      cpct_pkg::ST_DIV: div_done    = (div_cnt == '0) && out_free;
      default: ;
    endcase
  end

  function automatic logic [cpct_pkg::COUNT_W-1:0] sat_inc(
    input logic [cpct_pkg::COUNT_W-1:0] v
  );
    return (&v) ? v : v + cpct_pkg::COUNT_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cpct_pkg::ST_RUN;
      phase         <= cpct_pkg::PH_DISCHARGE;
      plate         <= '0;
      charge_ticks  <= '0;
      cycle_count   <= '0;
      elapsed_ticks <= '0;
      window_ticks  <= cpct_pkg::WINDOW_RESET;
      scale_shift   <= cpct_pkg::SHIFT_RESET;
      out_valid     <= 1'b0;
      div_cnt       <= '0;
    end else begin
      state <= state_next;

      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          cpct_pkg::REG_WINDOW_TICKS: window_ticks <= cfg.data[cpct_pkg::WINDOW_W-1:0];
          cpct_pkg::REG_SCALE_SHIFT:  scale_shift  <= cfg.data[cpct_pkg::SHIFT_W-1:0];
          default: ;
        endcase
      end

      if (result.ready && !div_done && !(accept && !window_end)) out_valid <= 1'b0;

      if (accept) begin
        if (window_end) begin
          charge_ticks  <= '0;
          cycle_count   <= '0;
          elapsed_ticks <= '0;
          plate         <= plate_inc;
          div_cnt       <= cpct_pkg::DIV_CNT_W'(cpct_pkg::READING_W);
        end else begin
          out_valid    <= 1'b1;
          out_rd_valid <= 1'b0;
          out_plate    <= plate;
          out_reading  <= '0;
          elapsed_ticks <= sat_inc(elapsed_ticks);
          if (phase == cpct_pkg::PH_DISCHARGE) begin
            out_drive <= drive;
            phase     <= cpct_pkg::PH_CHARGE;
          end else begin
            out_drive <= '0;
            if (!level) begin
              charge_ticks <= sat_inc(charge_ticks);
            end else begin
              cycle_count <= sat_inc(cycle_count);
              phase       <= cpct_pkg::PH_DISCHARGE;
            end
          end
        end
      end

      if (state == cpct_pkg::ST_DIV && div_cnt != '0) begin
        div_cnt <= div_cnt - cpct_pkg::DIV_CNT_W'(1);
      end

      if (div_done) begin
        out_valid    <= 1'b1;
        out_drive    <= '0;
        out_rd_valid <= 1'b1;
        out_plate    <= div_plate;
        out_reading  <= div_zero ? '0 : quo;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (accept && window_end) begin
      divisor   <= cycle_count;
      div_zero  <= (cycle_count == '0);
      div_plate <= plate;
      rem       <= '0;
      quo       <= dividend;
    end else if (state == cpct_pkg::ST_DIV && div_cnt != '0) begin
      rem <= ge ? diff[cpct_pkg::COUNT_W-1:0] : rem_sh[cpct_pkg::COUNT_W-1:0];
      quo <= {quo[cpct_pkg::READING_W-2:0], ge};
    end
  end

  assign result.valid           = out_valid;
  assign result.discharge_drive = out_drive;
  assign result.reading_valid   = out_rd_valid;
  assign result.plate_index     = out_plate;
  assign result.reading         = out_reading;

endmodule

>>> tb/cpct_charge_checker.sv
`timescale 1ns / 1ps

module cpct_charge_checker
  import cpct_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  cpct_sense_if  sense,
  cpct_result_if result,
  cpct_cfg_if    cfg,
  output int     pending,
  output int     errors
);

  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [SENSE_W-1:0]   drive;
    logic                 window_done;
    logic [PLATE_W-1:0]   plate;
    logic [READING_W-1:0] reading;
  } tick_out_t;

  tick_out_t           tick_out_q[$];
  logic [WINDOW_W-1:0] window_len;
  logic [SHIFT_W-1:0]  shift_amt;
  phase_t              phase;
  logic [PLATE_W-1:0]  cur_plate;
  logic [COUNT_W-1:0]  low_ticks;
  logic [COUNT_W-1:0]  charge_cycles;
  logic [COUNT_W-1:0]  elapsed;
  int                  err_cnt = 0;

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == COUNT_TOP) ? v : v + 1'b1;
  endfunction

  // Advance the charge-time meter by one tick and queue what it drives.
  task automatic predict_tick(input logic [SENSE_W-1:0] levels);
    tick_out_t          t;
    logic [PLATE_W-1:0] p;
    logic [SHIFT_W-1:0] sh;
    logic [63:0]        scaled;
    p = (cur_plate >= PLATE_W'(NUM_PLATES)) ? '0 : cur_plate;
    t = '0;
    t.plate = p;
    if (phase == PH_DISCHARGE) begin
      if (elapsed >= COUNT_W'(window_len)) begin
        sh = (shift_amt > MAX_SHIFT) ? MAX_SHIFT : shift_amt;
        if (charge_cycles != '0) begin
          scaled    = 64'(low_ticks) << sh;
          t.reading = READING_W'(scaled / 64'(charge_cycles));
        end
        t.window_done = 1'b1;
        low_ticks     = '0;
        charge_cycles = '0;
        elapsed       = '0;
        cur_plate     = (p == PLATE_W'(NUM_PLATES - 1)) ? '0 : p + 1'b1;
      end else begin
        t.drive   = SENSE_W'(1) << p;
        phase     = PH_CHARGE;
        elapsed   = bump(elapsed);
        cur_plate = p;
      end
    end else begin
      if (!levels[p]) begin
        low_ticks = bump(low_ticks);
      end else begin
        charge_cycles = bump(charge_cycles);
        phase         = PH_DISCHARGE;
      end
      elapsed   = bump(elapsed);
      cur_plate = p;
    end
    tick_out_q.push_back(t);
  endtask

  task automatic check_field(input string name, input logic [READING_W-1:0] want,
                             input logic [READING_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : monitor
    tick_out_t want;
    if (rst) begin
      window_len    = WINDOW_RESET;
      shift_amt     = SHIFT_RESET;
      phase         = PH_DISCHARGE;
      cur_plate     = '0;
      low_ticks     = '0;
      charge_cycles = '0;
      elapsed       = '0;
      tick_out_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_WINDOW_TICKS: window_len = cfg.data[WINDOW_W-1:0];
          REG_SCALE_SHIFT:  shift_amt  = cfg.data[SHIFT_W-1:0];
        endcase
      end
      if (sense.valid && sense.ready)
        predict_tick(sense.sense_levels);
      if (result.valid && result.ready) begin
        if (tick_out_q.size() == 0) begin
          $display("%0t: result transaction with none expected, actual %0h %0b %0h %0h",
                   $time, result.discharge_drive, result.reading_valid,
                   result.plate_index, result.reading);
          err_cnt++;
        end else begin
          want = tick_out_q.pop_front();
          check_field("discharge_drive", READING_W'(want.drive),
                      READING_W'(result.discharge_drive));
          check_field("reading_valid", READING_W'(want.window_done),
                      READING_W'(result.reading_valid));
          check_field("plate_index", READING_W'(want.plate),
                      READING_W'(result.plate_index));
          check_field("reading", want.reading, result.reading);
        end
      end
    end
    pending <= tick_out_q.size();
    errors  <= err_cnt;
  end

endmodule

>>> tb/capacitive_plate_charge_timer_tb.sv
`timescale 1ns / 1ps

module capacitive_plate_charge_timer_tb;
  import cpct_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 60;

  localparam logic [SENSE_W-1:0] RESET_SEQ [6]  = '{3'd0, 3'd7, 3'd0, 3'd1, 3'd7, 3'd0};
  localparam logic [SENSE_W-1:0] ZERO_SEQ  [4]  = '{3'd7, 3'd0, 3'd7, 3'd0};
  localparam logic [SENSE_W-1:0] STUCK_SEQ [12] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
                                                    3'd7, 3'd7, 3'd2, 3'd5, 3'd0, 3'd7};

  logic clk = 1'b0;
  logic rst;
  logic steady;
  logic squeeze;
  logic squeezed = 1'b0;
  int   cycles = 0;
  int   pending;
  int   errors;

  cpct_sense_if  sense_ch ();
  cpct_result_if result_ch ();
  cpct_cfg_if    cfg_ch ();

  capacitive_plate_charge_timer dut (
    .clk    (clk),
    .rst    (rst),
    .sense  (sense_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  cpct_charge_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .sense   (sense_ch),
    .result  (result_ch),
    .cfg     (cfg_ch),
    .pending (pending),
    .errors  (errors)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off so the block backs up.
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_ch.ready <= steady || ($urandom_range(99) >= 25);
      @(posedge clk);
    end
  end

  // valid stays high across back-to-back ticks; only gaps lower it
  task automatic send_tick(input logic [SENSE_W-1:0] lv);
    if (!steady && $urandom_range(99) < 25) begin
      sense_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    sense_ch.valid        <= 1'b1;
    sense_ch.sense_levels <= lv;
    do @(posedge clk); while (!sense_ch.ready);
  endtask

  task automatic drain();
    sense_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] win,
                            input logic [CFG_DATA_W-1:0] shift_word);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_WINDOW_TICKS;
    cfg_ch.data  <= win;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_SCALE_SHIFT;
    cfg_ch.data  <= shift_word;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // random upper bits; only the low five reach the shift register
  function automatic logic [CFG_DATA_W-1:0] shift_data(input int sh);
    return (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(5'h1f)) | CFG_DATA_W'(sh);
  endfunction

  task automatic run_random(input int count, input int high_pct);
    int                 low_run;
    logic [SENSE_W-1:0] lv;
    low_run = 0;
    repeat (count) begin
      if (low_run > 0) begin
        lv = '0;
        low_run--;
      end else begin
        // occasional stuck-low stretch across all plates
        if ($urandom_range(99) < 2)
          low_run = $urandom_range(5, 30);
        for (int b = 0; b < SENSE_W; b++)
          lv[b] = ($urandom_range(99) < high_pct);
      end
      send_tick(lv);
    end
  endtask

  initial begin
    sense_ch.valid        <= 1'b0;
    sense_ch.sense_levels <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_WINDOW_TICKS;
    cfg_ch.data           <= '0;
    steady                <= 1'b0;
    squeeze               <= 1'b0;
    rst                   <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset registers: long window, stays on plate X
    foreach (RESET_SEQ[i]) send_tick(RESET_SEQ[i]);
    drain();
    // zero window ends at once every tick; shift of 31 clamps to 16
    write_regs('0, '1);
    foreach (ZERO_SEQ[i]) send_tick(ZERO_SEQ[i]);
    drain();
    // line held low well past the window end
    write_regs(CFG_DATA_W'(2), CFG_DATA_W'(16));
    foreach (STUCK_SEQ[i]) send_tick(STUCK_SEQ[i]);
    drain();

    write_regs(CFG_DATA_W'(1), shift_data(0));
    run_random(330, 50);
    drain();
    write_regs(CFG_DATA_W'($urandom_range(2, 40)), shift_data(16));
    squeeze <= 1'b1;
    run_random(330, 25);
    drain();
    steady <= 1'b1;
    write_regs(CFG_DATA_W'($urandom_range(40, 300)), shift_data($urandom_range(0, 16)));
    run_random(330, 10);
    steady <= 1'b0;
    drain();
    write_regs(CFG_DATA_W'($urandom_range(1, 20)), shift_data($urandom_range(17, 31)));
    run_random(330, 25);
    drain();
    write_regs('1, shift_data($urandom_range(0, 31)));
    run_random(150, 50);
    drain();
    write_regs(CFG_DATA_W'($urandom_range(1, 500)), shift_data(10));
    run_random(330, 25);
    drain();
    write_regs('0, shift_data($urandom_range(0, 16)));
    run_random(100, 50);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
